FILE: design/efhs_pkg.sv
// ----------------------------------------------------------------------------
// efhs_pkg
// Shared types, codes and the ordering rule for the earliest-finish scheduler.
// ----------------------------------------------------------------------------
package efhs_pkg;

  localparam int MAX_SERVERS = 256;
  localparam int IDX_W       = $clog2(MAX_SERVERS);
  localparam int SIZE_W      = IDX_W + 1;
  localparam int CHILD_W     = IDX_W + 2;

  localparam int FT_W  = 64;
  localparam int DUR_W = 32;

  localparam logic [1:0] MODE_LOAD    = 2'd0;
  localparam logic [1:0] MODE_REQUEST = 2'd1;
  localparam logic [1:0] MODE_CLEAR   = 2'd2;

  localparam logic [2:0] ST_LOADED  = 3'd0;
  localparam logic [2:0] ST_SERVED  = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_EMPTY   = 3'd3;
  localparam logic [2:0] ST_CLEARED = 3'd4;

  typedef struct packed {
    logic [FT_W-1:0]  finish_time;
    logic [DUR_W-1:0] duration;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // a leaves before b: earlier finish, larger duration on a tie
  function automatic logic goes_first(entry_t a, entry_t b);
    logic res;
    if (a.finish_time != b.finish_time) begin
      res = a.finish_time < b.finish_time;
    end else begin
      res = a.duration > b.duration;
    end
    return res;
  endfunction

endpackage

FILE: design/efhs_ram.sv
// ----------------------------------------------------------------------------
// efhs_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module efhs_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: design/earliest_finish_heap_scheduler.sv
// ----------------------------------------------------------------------------
// earliest_finish_heap_scheduler
// Min-heap of servers ordered by next finish time, held in one RAM.
// ----------------------------------------------------------------------------
// The heap lives in a single RAM with one read and one write port and a
// registered read; the entry being moved is held in a register and written
// once at its final slot. Clear, a load into a full heap and a request on an
// empty heap are answered straight from idle. A load climbs the new server
// one level per parent compare (at most 8 levels for 256 servers). A request
// reads the root, then sinks the replacement level by level, reading the left
// and then the right child through the single read port before the winning
// child moves up into the hole. The result of a beat is registered, and the
// next input beat is taken once the heap update is finished and that register
// is free.
module earliest_finish_heap_scheduler (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_duration,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [63:0] out_finish_time,
  output logic [31:0] out_served_duration
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_UP_CMP   = 3'd1;
  localparam logic [2:0] S_UP_WR    = 3'd2;
  localparam logic [2:0] S_POP      = 3'd3;
  localparam logic [2:0] S_DN_START = 3'd4;
  localparam logic [2:0] S_DN_L     = 3'd5;
  localparam logic [2:0] S_DN_R     = 3'd6;

  localparam int IW = efhs_pkg::IDX_W;
  localparam int SW = efhs_pkg::SIZE_W;
  localparam int CW = efhs_pkg::CHILD_W;

  logic [2:0]          state_r, state_nxt;
  logic [SW-1:0]       size_r, size_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  efhs_pkg::entry_t    x_r, x_nxt;
  efhs_pkg::entry_t    best_r, best_nxt;
  logic [IW-1:0]       best_idx_r, best_idx_nxt;
  logic                best_child_r, best_child_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [2:0]          out_status_r, out_status_nxt;
  logic [63:0]         out_ft_r, out_ft_nxt;
  logic [31:0]         out_sd_r, out_sd_nxt;

  logic                ram_we;
  logic [IW-1:0]       ram_waddr;
  efhs_pkg::entry_t    ram_wdata;
  logic [IW-1:0]       ram_raddr;
  efhs_pkg::entry_t    ram_rdata;

  logic                accept;
  logic [IW-1:0]       size_idx;
  logic [IW-1:0]       parent_idx;
  logic [IW-1:0]       parent_size;
  logic [IW-1:0]       grand_idx;
  logic [CW-1:0]       left_c;
  logic [CW-1:0]       right_c;
  logic [CW-1:0]       size_c;
  logic [64:0]         adv_sum;
  logic [63:0]         adv_ft;
  efhs_pkg::entry_t    dec_ent;
  logic                dec_child;
  logic [IW-1:0]       dec_idx;
  logic                left_first;
  logic                right_first;

  efhs_ram #(
    .WIDTH (efhs_pkg::ENTRY_W),
    .DEPTH (efhs_pkg::MAX_SERVERS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  assign size_idx    = size_r[IW-1:0];
  assign parent_size = IW'((size_idx - IW'(1)) >> 1);
  assign parent_idx  = IW'((idx_r - IW'(1)) >> 1);
  assign grand_idx   = IW'((parent_idx - IW'(1)) >> 1);
  assign left_c      = (CW'(idx_r) << 1) + CW'(1);
  assign right_c     = left_c + CW'(1);
  assign size_c      = CW'(size_r);

  // advance with saturation
  assign adv_sum = {1'b0, ram_rdata.finish_time} + 65'(ram_rdata.duration);
  assign adv_ft  = adv_sum[64] ? '1 : adv_sum[63:0];

  assign left_first  = efhs_pkg::goes_first(ram_rdata, x_r);
  assign right_first = efhs_pkg::goes_first(ram_rdata, best_r);

  // winner of the current level, used in the last compare of that level
  always_comb begin
    if (state_r == S_DN_R) begin
      if (right_first) begin
        dec_ent   = ram_rdata;
        dec_child = 1'b1;
        dec_idx   = right_c[IW-1:0];
      end else begin
        dec_ent   = best_r;
        dec_child = best_child_r;
        dec_idx   = best_idx_r;
      end
    end else begin
      dec_ent   = left_first ? ram_rdata : x_r;
      dec_child = left_first;
      dec_idx   = left_c[IW-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    size_nxt       = size_r;
    idx_nxt        = idx_r;
    x_nxt          = x_r;
    best_nxt       = best_r;
    best_idx_nxt   = best_idx_r;
    best_child_nxt = best_child_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_ft_nxt     = out_ft_r;
    out_sd_nxt     = out_sd_r;
    ram_we         = 1'b0;
    ram_waddr      = idx_r;
    ram_wdata      = x_r;
    ram_raddr      = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          out_ft_nxt = '0;
          out_sd_nxt = '0;
          case (in_mode)
            efhs_pkg::MODE_LOAD: begin
              out_valid_nxt = 1'b1;
              if (size_r == SW'(efhs_pkg::MAX_SERVERS)) begin
                out_status_nxt = efhs_pkg::ST_FULL;
              end else begin
                out_status_nxt = efhs_pkg::ST_LOADED;
                x_nxt.finish_time = 64'(in_duration);
                x_nxt.duration    = in_duration;
                idx_nxt  = size_idx;
                size_nxt = size_r + SW'(1);
                if (size_r == '0) begin
                  ram_we    = 1'b1;
                  ram_waddr = '0;
                  ram_wdata = x_nxt;
                end else begin
                  ram_raddr = parent_size;
                  state_nxt = S_UP_CMP;
                end
              end
            end
            efhs_pkg::MODE_REQUEST: begin
              if (size_r == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = efhs_pkg::ST_EMPTY;
              end else begin
                ram_raddr = '0;
                state_nxt = S_POP;
              end
            end
            efhs_pkg::MODE_CLEAR: begin
              size_nxt       = '0;
              out_valid_nxt  = 1'b1;
              out_status_nxt = efhs_pkg::ST_CLEARED;
            end
            default: ;
          endcase
        end
      end
      S_UP_CMP: begin
        ram_we = 1'b1;
        if (efhs_pkg::goes_first(x_r, ram_rdata)) begin
          // parent moves down into the hole
          ram_wdata = ram_rdata;
          idx_nxt   = parent_idx;
          if (parent_idx == '0) begin
            state_nxt = S_UP_WR;
          end else begin
            ram_raddr = grand_idx;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_UP_WR: begin
        ram_we    = 1'b1;
        state_nxt = S_IDLE;
      end
      S_POP: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = efhs_pkg::ST_SERVED;
        out_ft_nxt     = ram_rdata.finish_time;
        out_sd_nxt     = ram_rdata.duration;
        x_nxt.finish_time = adv_ft;
        x_nxt.duration    = ram_rdata.duration;
        idx_nxt   = '0;
        state_nxt = S_DN_START;
      end
      S_DN_START: begin
        if (left_c >= size_c) begin
          ram_we    = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          ram_raddr = left_c[IW-1:0];
          state_nxt = S_DN_L;
        end
      end
      S_DN_L, S_DN_R: begin
        if (state_r == S_DN_L && right_c < size_c) begin
          best_nxt       = dec_ent;
          best_child_nxt = dec_child;
          best_idx_nxt   = dec_idx;
          ram_raddr      = right_c[IW-1:0];
          state_nxt      = S_DN_R;
        end else if (dec_child) begin
          // winning child moves up into the hole
          ram_we    = 1'b1;
          ram_wdata = dec_ent;
          idx_nxt   = dec_idx;
          state_nxt = S_DN_START;
        end else begin
          ram_we    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      size_r      <= size_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    x_r          <= x_nxt;
    best_r       <= best_nxt;
    best_idx_r   <= best_idx_nxt;
    best_child_r <= best_child_nxt;
    out_status_r <= out_status_nxt;
    out_ft_r     <= out_ft_nxt;
    out_sd_r     <= out_sd_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_finish_time     = out_ft_r;
  assign out_served_duration = out_sd_r;

endmodule

FILE: design/efhs_chk.sv
// ----------------------------------------------------------------------------
// efhs_chk
// Port-level checks for the earliest-finish scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module efhs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_mode,
  input logic [31:0] in_duration,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [63:0] out_finish_time,
  input logic [31:0] out_served_duration
);

  // a held result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_finish_time) && $stable(out_served_duration))
    else $error("result beat changed while stalled");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != efhs_pkg::ST_SERVED
      |-> out_finish_time == '0 && out_served_duration == '0)
    else $error("non-served result carries nonzero fields");

  // finish time starts at the duration and only grows or saturates
  a_finish_ge_dur: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == efhs_pkg::ST_SERVED
      |-> out_finish_time >= 64'(out_served_duration))
    else $error("served finish time below its duration");

  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == efhs_pkg::MODE_CLEAR
      |=> out_valid && out_status == efhs_pkg::ST_CLEARED)
    else $error("clear beat gave no cleared result");

  a_empty_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == efhs_pkg::MODE_CLEAR
      ##1 in_valid && in_ready && in_mode == efhs_pkg::MODE_REQUEST
      |=> out_valid && out_status == efhs_pkg::ST_EMPTY)
    else $error("request right after clear was not empty");

endmodule

bind earliest_finish_heap_scheduler efhs_chk u_efhs_chk (.*);
